// File: hw/rtl/wfpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpi_pkg: shared definitions for the wall-follow PI controller
// Widths, register map, command and status structs, the cos(atan(x)) table
// and the output saturation helper.
// ----------------------------------------------------------------------------
package wfpi_pkg;

  // Geometry of the sensor pair and size of the cosine table
  localparam int SENSOR_BASE     = 1638;
  localparam int COS_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(COS_TABLE_DEPTH);
  localparam int DIV_CNT_W       = $clog2(IDX_W);

  // Field widths
  localparam int RANGE_W = 14;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 24;
  localparam int COS_W   = 15;
  localparam int ERR_W   = RANGE_W + 1;
  localparam int INTEG_W = LIMIT_W + 1;
  localparam int SUM_W   = LIMIT_W + 2;
  localparam int MUL_A_W = SUM_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ROT_W   = PROD_W - 12;
  localparam int WIDE_W  = ROT_W + 1;

  // Index divider: remainder holds |d| * depth and the shifted divisor
  localparam int REM_W = RANGE_W + IDX_W + 4;
  localparam logic [REM_W-1:0] DIVISOR     = REM_W'(8 * SENSOR_BASE);
  localparam logic [REM_W-1:0] DEPTH_MULT  = REM_W'(COS_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_INDEX  = IDX_W'(COS_TABLE_DEPTH - 1);
  localparam logic [RANGE_W+3:0] STEEP_LIMIT = (RANGE_W + 4)'(8 * SENSOR_BASE);

  // APB register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_LINEAR_SPEED       = 3'd0,
    REG_KP_KEEP            = 3'd1,
    REG_KP_REACH           = 3'd2,
    REG_KI_KEEP            = 3'd3,
    REG_KI_REACH           = 3'd4,
    REG_REFERENCE_DISTANCE = 3'd5,
    REG_INTEGRATOR_LIMIT   = 3'd6,
    REG_DISTANCE_TOLERANCE = 3'd7
  } reg_idx_t;

  localparam logic [SPEED_W-1:0] RST_LINEAR_SPEED       = 16'd1638;
  localparam logic [GAIN_W-1:0]  RST_KP_KEEP            = 16'd614;
  localparam logic [GAIN_W-1:0]  RST_KP_REACH           = 16'd1229;
  localparam logic [GAIN_W-1:0]  RST_KI_KEEP            = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_KI_REACH           = 16'd0;
  localparam logic [RANGE_W-1:0] RST_REFERENCE_DISTANCE = 14'd655;
  localparam logic [LIMIT_W-1:0] RST_INTEGRATOR_LIMIT   = 24'd1638400;
  localparam logic [RANGE_W-1:0] RST_DISTANCE_TOLERANCE = 14'd164;

  typedef struct packed {
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [GAIN_W-1:0]  kp_keep;
    logic signed [GAIN_W-1:0]  kp_reach;
    logic signed [GAIN_W-1:0]  ki_keep;
    logic signed [GAIN_W-1:0]  ki_reach;
    logic [RANGE_W-1:0]        reference_distance;
    logic [LIMIT_W-1:0]        integrator_limit;
    logic [RANGE_W-1:0]        distance_tolerance;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_dist;
    logic decide;
    logic mul_p;
    logic mul_i;
    logic accum;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Cosine table built at elaboration
  typedef logic [COS_W-1:0] cos_tab_t [COS_TABLE_DEPTH];

  function automatic logic [31:0] isqrt32(input logic [31:0] n);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] bitv;
    rem  = n;
    root = '0;
    bitv = 32'h4000_0000;
    for (int k = 0; k < 16; k++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Shift-subtract quotient, used only while building the table
  function automatic logic [31:0] udiv32(input logic [31:0] num, input logic [31:0] den);
    logic [32:0] r;
    logic [31:0] q;
    r = '0;
    q = '0;
    for (int k = 31; k >= 0; k--) begin
      r = {r[31:0], num[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [31:0] r;
    logic [31:0] dep;
    dep = 32'(COS_TABLE_DEPTH);
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      r      = isqrt32(dep * dep + 32'd64 * 32'(i) * 32'(i));
      tab[i] = COS_W'(udiv32(32'd32768 * dep + r, r << 1));
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  // Clip a wide signed value to the 16-bit speed range
  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [SPEED_W-1:0] res;
    if (v > WIDE_W'(signed'(32767))) begin
      res = 16'sh7FFF;
    end else if (v < WIDE_W'(signed'(-32768))) begin
      res = 16'sh8000;
    end else begin
      res = v[SPEED_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/wfpi_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpi channel interfaces
// Valid/ready channels for range readings in and wheel speeds out.
// ----------------------------------------------------------------------------
interface wfpi_range_if;
  logic                             valid;
  logic                             ready;
  logic [wfpi_pkg::RANGE_W-1:0]     right_front_range;
  logic [wfpi_pkg::RANGE_W-1:0]     right_back_range;

  modport source (output valid, output right_front_range, output right_back_range,
                  input ready);
  modport sink   (input valid, input right_front_range, input right_back_range,
                  output ready);
endinterface

interface wfpi_wheel_if;
  logic                                valid;
  logic                                ready;
  logic signed [wfpi_pkg::SPEED_W-1:0] left_wheel_speed;
  logic signed [wfpi_pkg::SPEED_W-1:0] right_wheel_speed;
  logic                                keeping_reference;
  logic                                integrator_clamped;

  modport source (output valid, output left_wheel_speed, output right_wheel_speed,
                  output keeping_reference, output integrator_clamped, input ready);
  modport sink   (input valid, input left_wheel_speed, input right_wheel_speed,
                  input keeping_reference, input integrator_clamped, output ready);
endinterface

// File: hw/rtl/wfpi_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpi_regs: APB configuration registers
// Eight control registers at word addresses, written in the access phase.
// ----------------------------------------------------------------------------
module wfpi_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfpi_pkg::ADDR_W-1:0]   paddr,
  input  logic [wfpi_pkg::DATA_W-1:0]   pwdata,
  output logic [wfpi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output wfpi_pkg::cfg_t                cfg
);

  wfpi_pkg::reg_idx_t idx;

  assign idx    = wfpi_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_speed       <= wfpi_pkg::RST_LINEAR_SPEED;
      cfg.kp_keep            <= wfpi_pkg::RST_KP_KEEP;
      cfg.kp_reach           <= wfpi_pkg::RST_KP_REACH;
      cfg.ki_keep            <= wfpi_pkg::RST_KI_KEEP;
      cfg.ki_reach           <= wfpi_pkg::RST_KI_REACH;
      cfg.reference_distance <= wfpi_pkg::RST_REFERENCE_DISTANCE;
      cfg.integrator_limit   <= wfpi_pkg::RST_INTEGRATOR_LIMIT;
      cfg.distance_tolerance <= wfpi_pkg::RST_DISTANCE_TOLERANCE;
    end else if (psel && penable && pwrite) begin
      case (idx)
        wfpi_pkg::REG_LINEAR_SPEED:       cfg.linear_speed       <= pwdata[15:0];
        wfpi_pkg::REG_KP_KEEP:            cfg.kp_keep            <= pwdata[15:0];
        wfpi_pkg::REG_KP_REACH:           cfg.kp_reach           <= pwdata[15:0];
        wfpi_pkg::REG_KI_KEEP:            cfg.ki_keep            <= pwdata[15:0];
        wfpi_pkg::REG_KI_REACH:           cfg.ki_reach           <= pwdata[15:0];
        wfpi_pkg::REG_REFERENCE_DISTANCE: cfg.reference_distance <= pwdata[13:0];
        wfpi_pkg::REG_INTEGRATOR_LIMIT:   cfg.integrator_limit   <= pwdata[23:0];
        wfpi_pkg::REG_DISTANCE_TOLERANCE: cfg.distance_tolerance <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      wfpi_pkg::REG_LINEAR_SPEED:       prdata = {16'd0, cfg.linear_speed};
      wfpi_pkg::REG_KP_KEEP:            prdata = {16'd0, cfg.kp_keep};
      wfpi_pkg::REG_KP_REACH:           prdata = {16'd0, cfg.kp_reach};
      wfpi_pkg::REG_KI_KEEP:            prdata = {16'd0, cfg.ki_keep};
      wfpi_pkg::REG_KI_REACH:           prdata = {16'd0, cfg.ki_reach};
      wfpi_pkg::REG_REFERENCE_DISTANCE: prdata = {18'd0, cfg.reference_distance};
      wfpi_pkg::REG_INTEGRATOR_LIMIT:   prdata = {8'd0, cfg.integrator_limit};
      wfpi_pkg::REG_DISTANCE_TOLERANCE: prdata = {18'd0, cfg.distance_tolerance};
      default:                          prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/wfpi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpi_ctrl: sequencing state machine
// Steps the datapath through index divide, distance multiply, mode decision,
// the two gain products and the final update.
// ----------------------------------------------------------------------------
module wfpi_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  wfpi_pkg::dp_status_t   status,
  output wfpi_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_MUL_DIST,
    S_DECIDE,
    S_MUL_P,
    S_MUL_I,
    S_ACCUM,
    S_FINISH
  } state_t;

  state_t                         state;
  logic [wfpi_pkg::DIV_CNT_W-1:0] cnt;

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIVIDE);
    cmd.mul_dist = (state == S_MUL_DIST);
    cmd.decide   = (state == S_DECIDE);
    cmd.mul_p    = (state == S_MUL_P);
    cmd.mul_i    = (state == S_MUL_I);
    cmd.accum    = (state == S_ACCUM);
    cmd.finish   = (state == S_FINISH) && status.out_free;
  end

  assign in_ready = (state == S_IDLE);

  // Advance state and the divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          cnt <= cnt + 1'b1;
          if (cnt == wfpi_pkg::DIV_CNT_W'(wfpi_pkg::IDX_W - 1)) state <= S_MUL_DIST;
        end
        S_MUL_DIST: state <= S_DECIDE;
        S_DECIDE:   state <= S_MUL_P;
        S_MUL_P:    state <= S_MUL_I;
        S_MUL_I:    state <= S_ACCUM;
        S_ACCUM:    state <= S_FINISH;
        S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/wfpi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpi_dp: controller datapath
// Range capture, shift-subtract table index divider, cosine table, one shared
// multiplier, mode decision, PI accumulation, integrator clamp and the
// output register.
// ----------------------------------------------------------------------------
module wfpi_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wfpi_pkg::ctrl_cmd_t                 cmd,
  output wfpi_pkg::dp_status_t                status,
  input  wfpi_pkg::cfg_t                      cfg,
  input  logic [wfpi_pkg::RANGE_W-1:0]        front,
  input  logic [wfpi_pkg::RANGE_W-1:0]        back,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wfpi_pkg::SPEED_W-1:0] left_speed,
  output logic signed [wfpi_pkg::SPEED_W-1:0] right_speed,
  output logic                                out_keep,
  output logic                                out_clamped
);

  localparam int RW = wfpi_pkg::RANGE_W;
  localparam int EW = wfpi_pkg::ERR_W;

  // Captured item and intermediate registers
  logic [RW-1:0]                          mean;
  logic signed [EW-1:0]                   d;
  logic                                   steep;
  logic [wfpi_pkg::REM_W-1:0]             rem;
  logic [wfpi_pkg::REM_W-1:0]             dsh;
  logic [wfpi_pkg::IDX_W-1:0]             quo;
  logic signed [wfpi_pkg::PROD_W-1:0]     prod;
  logic                                   keep;
  logic signed [EW-1:0]                   err;
  logic signed [wfpi_pkg::GAIN_W-1:0]     kp;
  logic signed [wfpi_pkg::GAIN_W-1:0]     ki;
  logic signed [wfpi_pkg::SUM_W-1:0]      sum;
  logic signed [wfpi_pkg::PROD_W-1:0]     acc;
  logic signed [wfpi_pkg::INTEG_W-1:0]    integ;

  // Combinational terms
  logic [RW-1:0]                          ad_in;
  logic [RW:0]                            pair_sum;
  logic [wfpi_pkg::IDX_W-1:0]             idx;
  logic [wfpi_pkg::COS_W-1:0]             cos_val;
  logic signed [wfpi_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [wfpi_pkg::MUL_B_W-1:0]    mul_b;
  logic [RW-1:0]                          wall_dist;
  logic signed [EW-1:0]                   band_diff;
  logic signed [EW-1:0]                   band_abs;
  logic                                   keep_next;
  logic signed [EW-1:0]                   err_next;
  logic signed [wfpi_pkg::ROT_W-1:0]      rot;
  logic signed [wfpi_pkg::WIDE_W-1:0]     lin_w;
  logic signed [wfpi_pkg::WIDE_W-1:0]     rot_w;
  logic signed [wfpi_pkg::SUM_W-1:0]      lim_s;
  logic signed [wfpi_pkg::INTEG_W-1:0]    lim_i;
  logic                                   over;

  assign status.out_free = !out_valid || out_ready;

  // Range difference and mean
  assign ad_in    = (back >= front) ? (back - front) : (front - back);
  assign pair_sum = {1'b0, front} + {1'b0, back};

  // Table lookup, saturated for steep angles
  assign idx     = steep ? wfpi_pkg::LAST_INDEX : quo;
  assign cos_val = wfpi_pkg::COS_TAB[idx];

  // Shared multiplier operand select
  always_comb begin
    if (cmd.mul_p) begin
      mul_a = wfpi_pkg::MUL_A_W'(err);
      mul_b = wfpi_pkg::MUL_B_W'(kp);
    end else if (cmd.mul_i) begin
      mul_a = wfpi_pkg::MUL_A_W'(sum);
      mul_b = wfpi_pkg::MUL_B_W'(ki);
    end else begin
      mul_a = signed'({{(wfpi_pkg::MUL_A_W - RW){1'b0}}, mean});
      mul_b = signed'({{(wfpi_pkg::MUL_B_W - wfpi_pkg::COS_W){1'b0}}, cos_val});
    end
  end

  // Keep or reach decision from the projected distance
  assign wall_dist = prod[2*RW-1:RW];
  assign band_diff = signed'({1'b0, cfg.reference_distance}) - signed'({1'b0, wall_dist});
  assign band_abs  = band_diff[EW-1] ? -band_diff : band_diff;
  assign keep_next = band_abs < signed'({1'b0, cfg.distance_tolerance});
  assign err_next  = keep_next ? d
                               : signed'({1'b0, cfg.reference_distance}) - signed'({1'b0, mean});

  // Final rotation, wheel sums and clamp test
  assign rot   = acc[wfpi_pkg::PROD_W-1:12];
  assign lin_w = wfpi_pkg::WIDE_W'(cfg.linear_speed);
  assign rot_w = wfpi_pkg::WIDE_W'(rot);
  assign lim_s = signed'({2'b00, cfg.integrator_limit});
  assign lim_i = signed'({1'b0, cfg.integrator_limit});
  assign over  = (sum > lim_s) || (sum < -lim_s);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean  <= pair_sum[RW:1];
      d     <= signed'({1'b0, back}) - signed'({1'b0, front});
      steep <= {4'b0000, ad_in} >= wfpi_pkg::STEEP_LIMIT;
      rem   <= wfpi_pkg::REM_W'(ad_in) * wfpi_pkg::DEPTH_MULT;
      dsh   <= wfpi_pkg::DIVISOR << (wfpi_pkg::IDX_W - 1);
      quo   <= '0;
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[wfpi_pkg::IDX_W-2:0], 1'b1};
      end else begin
        quo <= {quo[wfpi_pkg::IDX_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.mul_dist || cmd.mul_p || cmd.mul_i) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.decide) begin
      keep <= keep_next;
      err  <= err_next;
      kp   <= keep_next ? cfg.kp_keep : cfg.kp_reach;
      ki   <= keep_next ? cfg.ki_keep : cfg.ki_reach;
      sum  <= wfpi_pkg::SUM_W'(integ) + wfpi_pkg::SUM_W'(err_next);
    end
    // Rounding offset rides in with the proportional term
    if (cmd.mul_i) begin
      acc <= prod + wfpi_pkg::PROD_W'(signed'(2048));
    end
    if (cmd.accum) begin
      acc <= acc + prod;
    end
    if (cmd.finish) begin
      left_speed  <= wfpi_pkg::sat16(lin_w - rot_w);
      right_speed <= wfpi_pkg::sat16(lin_w + rot_w);
      out_keep    <= keep;
      out_clamped <= over;
    end
  end

  // Integrator and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        if (over) begin
          integ <= sum[wfpi_pkg::SUM_W-1] ? -lim_i : lim_i;
        end else begin
          integ <= sum[wfpi_pkg::INTEG_W-1:0];
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/wall_follow_pi_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_follow_pi_controller: wall-following PI controller
// Per tick: wall angle index, projected distance, keep/reach mode choice,
// PI rotation with a clamped integrator, and saturated wheel speeds.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  ranges   | in  | valid/ready        | right_front_range, right_back_range
//  wheels   | out | valid/ready        | left/right_wheel_speed, keeping_reference,
//           |     |                    | integrator_clamped
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata (8 registers)
//
// A request is captured on acceptance, then runs IDX_W (8) shift-subtract steps of
// the table index divider, then six steps around the single shared multiplier
// (distance, kp term, ki term) before the next request can be accepted.
// Reset is synchronous; it clears the integrator and the control state and
// loads the register defaults. The result sits in an output register, so a
// stalled wheels channel only holds the final step once a second result is
// ready; a new request is taken while the previous result waits.
// ----------------------------------------------------------------------------
module wall_follow_pi_controller (
  input  logic                         clk,
  input  logic                         rst,
  wfpi_range_if.sink                   ranges,
  wfpi_wheel_if.source                 wheels,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wfpi_pkg::ADDR_W-1:0]  paddr,
  input  logic [wfpi_pkg::DATA_W-1:0]  pwdata,
  output logic [wfpi_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  wfpi_pkg::cfg_t       cfg;
  wfpi_pkg::ctrl_cmd_t  cmd;
  wfpi_pkg::dp_status_t status;

  // Configuration registers
  wfpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  wfpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ranges.valid),
    .in_ready (ranges.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic
  wfpi_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg),
    .front       (ranges.right_front_range),
    .back        (ranges.right_back_range),
    .out_valid   (wheels.valid),
    .out_ready   (wheels.ready),
    .left_speed  (wheels.left_wheel_speed),
    .right_speed (wheels.right_wheel_speed),
    .out_keep    (wheels.keeping_reference),
    .out_clamped (wheels.integrator_clamped)
  );

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.mul_dist, cmd.decide,
              cmd.mul_p, cmd.mul_i, cmd.accum, cmd.finish}))
    else $error("more than one datapath command active");

  // An accepted request closes the input until it is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (ranges.valid && ranges.ready) |=> !ranges.ready)
    else $error("input reopened right after a request");

  // Finishing presents a result and reopens the input
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (wheels.valid && ranges.ready))
    else $error("finish did not publish a result");

  // No finish while the previous result is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!wheels.valid || wheels.ready))
    else $error("result overwritten before it was taken");

endmodule
